FILE: hw/rtl/dtpq_pkg.sv
// Shared widths, types and defaults of the deferred task priority queue.
package dtpq_pkg;

	localparam int ID_W = 8;
	localparam int PRI_W = 4;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int CMD_FIFO_DEPTH = 2;

	// One offered task as it travels from the front to the back.
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
	} cmd_t;

	// Handshake between the command queue and the execution engine.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_if_t;

endpackage

FILE: hw/rtl/dtpq_cmd_fifo.sv
// Front part: accepts offered tasks into a short command queue.
module dtpq_cmd_fifo
	import dtpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             task_valid,
	output logic             task_stall,
	input  logic [ID_W-1:0]  task_id,
	input  logic [PRI_W-1:0] priority_req,
	output cmd_if_t          head,
	input  logic             pop
);

	localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t             mem_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             do_pop;

	// A transfer in is taken whenever there is room left.
	assign task_stall = (count_q == CNT_W'(CMD_FIFO_DEPTH));
	assign push       = task_valid && !task_stall;
	assign do_pop     = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	// Storage of the queued commands.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{id: task_id, pri: priority_req};
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/dtpq_engine.sv
// Back part: sorted task store with insert, drop and drain, and the result register.
module dtpq_engine
	import dtpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_if_t          head,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [ID_W-1:0]  task_id_res,
	output logic [PRI_W-1:0] priority_res,
	output logic             dropped,
	output logic             last
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ID_W-1:0]  ids_q  [QUEUE_DEPTH];
	logic [PRI_W-1:0] pris_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] le;
	logic             out_free;
	logic             head_wins;
	logic             full;
	logic             do_insert;
	logic             do_shift;
	logic             emit;
	logic [ID_W-1:0]  emit_id;
	logic [PRI_W-1:0] emit_pri;
	logic             emit_drop;
	logic             emit_last;

	assign out_free  = !res_valid || !res_stall;
	assign head_wins = (cnt_q == '0) || (head.cmd.pri < pris_q[0]);
	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));

	// Entries that sort ahead of the new task; being sorted, they form a prefix.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i] = (CNT_W'(i) < cnt_q) && (pris_q[i] <= head.cmd.pri);
		end
	end

	// Decide what the current command or drain step does this cycle.
	always_comb begin
		pop       = 1'b0;
		do_insert = 1'b0;
		do_shift  = 1'b0;
		emit      = 1'b0;
		emit_id   = head.cmd.id;
		emit_pri  = head.cmd.pri;
		emit_drop = 1'b0;
		emit_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					if (head_wins) begin
						if (out_free) begin
							pop       = 1'b1;
							emit      = 1'b1;
							emit_last = (cnt_q == '0);
						end
					end else if (full) begin
						if (out_free) begin
							pop       = 1'b1;
							emit      = 1'b1;
							emit_drop = 1'b1;
						end
					end else begin
						pop       = 1'b1;
						do_insert = 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					emit      = 1'b1;
					do_shift  = 1'b1;
					emit_id   = ids_q[0];
					emit_pri  = pris_q[0];
					emit_last = (cnt_q == CNT_W'(1));
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Each entry either keeps its task, takes the new one, or moves by one place.
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (!le[g]) begin
					if (g == 0) begin
						ids_q[g]  <= head.cmd.id;
						pris_q[g] <= head.cmd.pri;
					end else if (le[(g == 0) ? 0 : g-1]) begin
						ids_q[g]  <= head.cmd.id;
						pris_q[g] <= head.cmd.pri;
					end else begin
						ids_q[g]  <= ids_q[(g == 0) ? 0 : g-1];
						pris_q[g] <= pris_q[(g == 0) ? 0 : g-1];
					end
				end
			end else if (do_shift && (g < QUEUE_DEPTH - 1)) begin
				ids_q[g]  <= ids_q[(g < QUEUE_DEPTH - 1) ? g+1 : g];
				pris_q[g] <= pris_q[(g < QUEUE_DEPTH - 1) ? g+1 : g];
			end
		end
	end

	// Control state: fill count and drain sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			if (do_insert) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_shift) begin
				cnt_q <= cnt_q - 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (emit && !emit_drop && (cnt_q != '0)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (do_shift && (cnt_q == CNT_W'(1))) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (emit) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	// Result register: payload, held while the transfer out is stalled.
	always_ff @(posedge clk) begin
		if (emit) begin
			task_id_res  <= emit_id;
			priority_res <= emit_pri;
			dropped      <= emit_drop;
			last         <= emit_last;
		end
	end

endmodule

FILE: hw/rtl/deferred_task_priority_queue_core.sv
// Path: with the engine idle and the output free, a task that wins against the store head or
// is dropped goes from the command queue into the result register; a drain in progress or a
// stalled output delays it. Throughput: an insert goes into the sorted store without a result;
// a drain gives one result per cycle unless the output stalls, queue count plus one results.
// A drop gives one result. Inputs wait in a two-entry command queue.
// Reset (arst_n low, asynchronous) empties the task store and the command queue.
module deferred_task_priority_queue_core
	import dtpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             task_valid,
	output logic             task_stall,
	input  logic [ID_W-1:0]  task_id,
	input  logic [PRI_W-1:0] priority_req,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [ID_W-1:0]  task_id_res,
	output logic [PRI_W-1:0] priority_res,
	output logic             dropped,
	output logic             last
);

	cmd_if_t head;
	logic    pop;

	// Front: command queue.
	dtpq_cmd_fifo u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.task_valid   (task_valid),
		.task_stall   (task_stall),
		.task_id      (task_id),
		.priority_req (priority_req),
		.head         (head),
		.pop          (pop)
	);

	// Back: sorted store and result generation.
	dtpq_engine #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.task_id_res  (task_id_res),
		.priority_res (priority_res),
		.dropped      (dropped),
		.last         (last)
	);

endmodule
